// ===== src/elpp_pkg.sv =====
// ----------------------------------------------------------------------------
// elpp_pkg
// Shared types and constants for the edge list pair parser.
// ----------------------------------------------------------------------------
package elpp_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int NODE_BITS   = 32;
   localparam int BYTE_BITS   = 8;
   localparam int DIGIT_BITS  = 4;
   localparam int OPT_BITS    = 3;

   localparam logic [BYTE_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_BITS-1:0] CHAR_MINUS   = 8'h2d;
   localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE = 8'h0a;

   // option bit positions
   localparam int OPT_DECREMENT = 0;
   localparam int OPT_TRANSPOSE = 1;
   localparam int OPT_ASCENDING = 2;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [NODE_BITS-1:0]  node_type;

   typedef enum logic [4:0] {
      PH_SEEK1 = 5'b00001,
      PH_DIG1  = 5'b00010,
      PH_SEEK2 = 5'b00100,
      PH_DIG2  = 5'b01000,
      PH_SKIP  = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      ST_PAIR     = 2'd0,
      ST_LINE_END = 2'd1,
      ST_FILE_END = 2'd2
   } status_type;

   typedef struct packed {
      logic       valid;
      value_type  first;
      value_type  second;
      status_type status;
      logic       file_done;
   } pair_event_type;

   typedef struct packed {
      logic       file_done;
      status_type status;
      node_type   second_node;
      node_type   first_node;
   } result_type;

endpackage

// ===== src/edge_list_pair_parser.sv =====
// ----------------------------------------------------------------------------
// edge_list_pair_parser
// Parses a text byte stream into pairs of decimal node ids, one byte a cycle while the result is not stalled.
//
//   channel  direction  payload
//   req      in         tdata: text_byte[7:0]; tlast: end_of_file
//   rsp      out        tdata: first_node[31:0], second_node[63:32]
//                       tuser: status[1:0], file_done[2]
//   csr      in         data: load_options[2:0], always ready
//
// One byte is taken every cycle while the result is not stalled; a result
// passes through the input register, then the parse and option logic into
// the result register. Reset clears the parse state and options.
// A stalled result holds the parse stage; the input register still takes one
// byte if it is empty.
// ----------------------------------------------------------------------------
module edge_list_pair_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // text_byte
   input  logic                           req_tlast,   // end_of_file
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,   // first_node, second_node
   output logic [2:0]                     rsp_tuser,   // status, file_done
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [elpp_pkg::OPT_BITS-1:0]  csr_data     // load_options
);

   logic                                 in_valid_ff, in_valid_in;
   logic [elpp_pkg::BYTE_BITS-1:0]       in_byte_ff;
   logic                                 in_eof_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   elpp_pkg::result_type                 result_ff;
   logic [elpp_pkg::OPT_BITS-1:0]        options_ff;

   logic                                 step;
   logic                                 req_take;
   elpp_pkg::pair_event_type             pair_event;
   elpp_pkg::result_type                 result;

   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign rsp_valid_in = step ? pair_event.valid : (rsp_valid_ff && !rsp_tready);

   elpp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .text_byte   (in_byte_ff),
      .end_of_file (in_eof_ff),
      .pair_event  (pair_event)
   );

   elpp_format u_format (
      .load_options (options_ff),
      .pair_event   (pair_event),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         options_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            options_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_eof_ff  <= req_tlast;
      end
      if (step && pair_event.valid) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {result_ff.second_node, result_ff.first_node};
   assign rsp_tuser  = {result_ff.file_done, result_ff.status};

endmodule

// ===== src/elpp_parse.sv =====
// ----------------------------------------------------------------------------
// elpp_parse
// Per-byte parse state machine: number search, digit accumulation, line skip.
// ----------------------------------------------------------------------------
module elpp_parse (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [elpp_pkg::BYTE_BITS-1:0] text_byte,
   input  logic                           end_of_file,
   output elpp_pkg::pair_event_type       pair_event
);

   elpp_pkg::phase_type phase_ff, phase_in;
   elpp_pkg::value_type acc_ff, acc_in;
   elpp_pkg::value_type held_ff, held_in;
   logic                neg_ff, neg_in;

   logic                                   is_digit;
   logic                                   is_newline;
   logic                                   is_minus;
   logic [elpp_pkg::DIGIT_BITS-1:0]        digit;
   elpp_pkg::value_type                    acc_times_ten;
   elpp_pkg::value_type                    finished;

   assign is_digit   = !end_of_file && (text_byte >= elpp_pkg::CHAR_ZERO)
                       && (text_byte <= elpp_pkg::CHAR_NINE);
   assign is_newline = !end_of_file && (text_byte == elpp_pkg::CHAR_NEWLINE);
   assign is_minus   = !end_of_file && (text_byte == elpp_pkg::CHAR_MINUS);
   assign digit      = elpp_pkg::DIGIT_BITS'(text_byte - elpp_pkg::CHAR_ZERO);

   assign acc_times_ten = {acc_ff[elpp_pkg::VALUE_BITS-4:0], 3'b000}
                        + {acc_ff[elpp_pkg::VALUE_BITS-2:0], 1'b0}
                        + elpp_pkg::value_type'(digit);
   assign finished = neg_ff ? (elpp_pkg::value_type'(0) - acc_ff) : acc_ff;

   always_comb begin
      phase_in             = phase_ff;
      acc_in               = acc_ff;
      neg_in               = neg_ff;
      held_in              = held_ff;
      pair_event.valid     = 1'b0;
      pair_event.first     = held_ff;
      pair_event.second    = finished;
      pair_event.status    = elpp_pkg::ST_PAIR;
      pair_event.file_done = end_of_file;
      case (phase_ff)
         elpp_pkg::PH_SEEK1, elpp_pkg::PH_SEEK2: begin
            if (is_digit) begin
               acc_in   = elpp_pkg::value_type'(digit);
               phase_in = (phase_ff == elpp_pkg::PH_SEEK1) ? elpp_pkg::PH_DIG1
                                                           : elpp_pkg::PH_DIG2;
            end else if (is_newline || end_of_file) begin
               pair_event.valid  = 1'b1;
               pair_event.status = end_of_file ? elpp_pkg::ST_FILE_END
                                               : elpp_pkg::ST_LINE_END;
               phase_in = elpp_pkg::PH_SEEK1;
               acc_in   = '0;
               neg_in   = 1'b0;
            end else if (is_minus) begin
               neg_in = 1'b1;
            end
         end
         elpp_pkg::PH_DIG1: begin
            if (is_digit) begin
               acc_in = acc_times_ten;
            end else begin
               held_in = finished;
               acc_in  = '0;
               neg_in  = 1'b0;
               if (end_of_file) begin
                  pair_event.valid  = 1'b1;
                  pair_event.status = elpp_pkg::ST_FILE_END;
                  phase_in          = elpp_pkg::PH_SEEK1;
               end else begin
                  phase_in = elpp_pkg::PH_SEEK2;
               end
            end
         end
         elpp_pkg::PH_DIG2: begin
            if (is_digit) begin
               acc_in = acc_times_ten;
            end else if (is_newline || end_of_file) begin
               pair_event.valid = 1'b1;
               phase_in         = elpp_pkg::PH_SEEK1;
               acc_in           = '0;
               neg_in           = 1'b0;
            end else begin
               acc_in   = finished;
               neg_in   = 1'b0;
               phase_in = elpp_pkg::PH_SKIP;
            end
         end
         elpp_pkg::PH_SKIP: begin
            pair_event.second = acc_ff;
            if (is_newline || end_of_file) begin
               pair_event.valid = 1'b1;
               phase_in         = elpp_pkg::PH_SEEK1;
               acc_in           = '0;
               neg_in           = 1'b0;
            end
         end
         default: begin
            phase_in = elpp_pkg::PH_SEEK1;
            acc_in   = '0;
            neg_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= elpp_pkg::PH_SEEK1;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         held_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== src/elpp_format.sv =====
// ----------------------------------------------------------------------------
// elpp_format
// Applies the load options to a parsed pair and builds the result item.
// ----------------------------------------------------------------------------
module elpp_format (
   input  logic [elpp_pkg::OPT_BITS-1:0] load_options,
   input  elpp_pkg::pair_event_type      pair_event,
   output elpp_pkg::result_type          result
);

   elpp_pkg::value_type x_dec;
   elpp_pkg::value_type y_dec;
   elpp_pkg::value_type x_out;
   elpp_pkg::value_type y_out;
   logic                swap;

   always_comb begin
      if (load_options[elpp_pkg::OPT_DECREMENT]) begin
         x_dec = pair_event.first - elpp_pkg::value_type'(1);
         y_dec = pair_event.second - elpp_pkg::value_type'(1);
      end else begin
         x_dec = pair_event.first;
         y_dec = pair_event.second;
      end
      swap = load_options[elpp_pkg::OPT_TRANSPOSE]
             || (load_options[elpp_pkg::OPT_ASCENDING] && ($signed(x_dec) > $signed(y_dec)));
      x_out = swap ? y_dec : x_dec;
      y_out = swap ? x_dec : y_dec;

      result.status    = pair_event.status;
      result.file_done = pair_event.file_done;
      if (pair_event.status == elpp_pkg::ST_PAIR) begin
         result.first_node  = elpp_pkg::NODE_BITS'($signed(x_out));
         result.second_node = elpp_pkg::NODE_BITS'($signed(y_out));
      end else begin
         result.first_node  = '0;
         result.second_node = '0;
      end
   end

endmodule
